// ===== rtl/pmnc_pkg.sv =====
// Shared types and constants for the prefix match next-character set block.
// Holds opcodes, result codes, the controller state type and the command
// and status structs that join the controller and the datapath.
package pmnc_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_PREFIX = 2'd1;
  localparam logic [1:0] OP_ADDR   = 2'd2;
  localparam logic [1:0] OP_REPORT = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_WORD   = 2'd2;

  // Report status codes.
  localparam logic [1:0] STAT_NONE = 2'd0;
  localparam logic [1:0] STAT_ONE  = 2'd1;
  localparam logic [1:0] STAT_MANY = 2'd2;

  // The 256-bit next-character set is held as four 64-bit words.
  localparam int SET_BITS  = 256;
  localparam int WORD_BITS = 64;
  localparam int SET_WORDS = SET_BITS / WORD_BITS;

  // Match counter saturation value.
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_END_RD,
    S_END,
    S_REP_RD,
    S_REP_LD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic exec;
    logic end_rd;
    logic end_do;
    logic rep_rd;
    logic rep_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       eos;
    logic       rep_last;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== rtl/pmnc_in_if.sv =====
// Input channel interface of the prefix match next-character set block.
// Carries the valid/ready handshake and one input item; no dependencies.
interface pmnc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] char_value;
  logic       end_of_string;

  modport source (output valid, operation, char_value, end_of_string, input ready);
  modport sink (input valid, operation, char_value, end_of_string, output ready);
  modport monitor (input valid, ready, operation, char_value, end_of_string);
endinterface

// ===== rtl/pmnc_out_if.sv =====
// Result channel interface of the prefix match next-character set block.
// Carries the valid/ready handshake and one result item; no dependencies.
interface pmnc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [7:0]  match_count;
  logic [7:0]  out_char;
  logic [63:0] set_word;
  logic [1:0]  word_index;
  logic        last;

  modport source (output valid, kind, status, match_count, out_char, set_word,
                  word_index, last, input ready);
  modport sink (input valid, kind, status, match_count, out_char, set_word,
                word_index, last, output ready);
  modport monitor (input valid, ready, kind, status, match_count, out_char,
                   set_word, word_index, last);
endinterface

// ===== rtl/pmnc_ctrl.sv =====
// Controller state machine of the prefix match next-character set block.
// Sequences item execution, address completion and report runs.
// Depends on pmnc_pkg.
module pmnc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  pmnc_pkg::dp_status_t stat,
  output pmnc_pkg::dp_cmd_t    cmd
);

  pmnc_pkg::state_t state;
  pmnc_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmnc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      pmnc_pkg::S_IDLE: begin
        item_ready    = 1'b1;
        cmd.load_item = item_valid;
        if (item_valid) begin
          state_next = pmnc_pkg::S_EXEC;
        end
      end
      pmnc_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.op == pmnc_pkg::OP_ADDR && stat.eos) begin
          state_next = pmnc_pkg::S_END_RD;
        end else if (stat.op == pmnc_pkg::OP_REPORT) begin
          state_next = pmnc_pkg::S_REP_RD;
        end else begin
          state_next = pmnc_pkg::S_IDLE;
        end
      end
      pmnc_pkg::S_END_RD: begin
        cmd.end_rd = 1'b1;
        state_next = pmnc_pkg::S_END;
      end
      pmnc_pkg::S_END: begin
        cmd.end_do = 1'b1;
        state_next = pmnc_pkg::S_IDLE;
      end
      pmnc_pkg::S_REP_RD: begin
        cmd.rep_rd = 1'b1;
        state_next = pmnc_pkg::S_REP_LD;
      end
      pmnc_pkg::S_REP_LD: begin
        // Wait for the output register to free up, then load one result.
        cmd.rep_load = stat.out_free;
        if (stat.out_free) begin
          state_next = stat.rep_last ? pmnc_pkg::S_IDLE : pmnc_pkg::S_REP_RD;
        end
      end
      default: begin
        state_next = pmnc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/pmnc_dp.sv =====
// Datapath of the prefix match next-character set block: prefix and
// address memories, match state, the next-character set and the output
// register. Depends on pmnc_pkg; driven by pmnc_ctrl commands.
module pmnc_dp #(
  parameter int MAX_LEN = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pmnc_pkg::dp_cmd_t     cmd,
  output pmnc_pkg::dp_status_t  stat,
  input  logic [1:0]           operation,
  input  logic [7:0]           char_value,
  input  logic                 end_of_string,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [1:0]           kind,
  output logic [1:0]           status,
  output logic [7:0]           match_count,
  output logic [7:0]           out_char,
  output logic [63:0]          set_word,
  output logic [1:0]           word_index,
  output logic                 last
);

  localparam int AW = $clog2(MAX_LEN);       // memory index width
  localparam int PW = $clog2(MAX_LEN + 2);   // position, saturates at MAX_LEN+1
  localparam int LW = $clog2(MAX_LEN + 1);   // lengths up to MAX_LEN
  localparam int KW = $clog2(MAX_LEN + 2);   // report run counter

  // Latched input item.
  logic [1:0] op_q;
  logic [7:0] ch_q;
  logic       eos_q;

  // Memories and their registered read data.
  logic [7:0] prefix_mem [MAX_LEN];
  logic [7:0] buf_mem    [2][MAX_LEN];
  logic [7:0] pref_rd;
  logic [7:0] buf_rd;

  // Match state.
  logic [LW-1:0] prefix_length;
  logic          prefix_too_long;
  logic          found_select;
  logic [LW-1:0] found_length;
  logic [PW-1:0] position;
  logic          still_matching;
  logic [63:0]   enable_set [pmnc_pkg::SET_WORDS];
  logic [7:0]    match_total;

  // Report run state.
  logic [1:0]    rep_status;
  logic [KW-1:0] rep_n;
  logic [KW-1:0] rep_k;

  logic          back;
  logic          do_clear;
  logic          do_prefix;
  logic          do_addr;
  logic          rep_start;
  logic          is_match;
  logic [KW-1:0] k_minus;
  logic [1:0]    stat_now;

  assign back      = ~found_select;
  assign do_clear  = cmd.exec && (op_q == pmnc_pkg::OP_CLEAR);
  assign do_prefix = cmd.exec && (op_q == pmnc_pkg::OP_PREFIX) && (ch_q != 8'd0);
  assign do_addr   = cmd.exec && (op_q == pmnc_pkg::OP_ADDR) && (ch_q != 8'd0);
  assign rep_start = cmd.exec && (op_q == pmnc_pkg::OP_REPORT);
  assign k_minus   = rep_k - KW'(1);

  // A completed address matches when it never diverged and fits the limits.
  assign is_match = still_matching && !prefix_too_long &&
                    (position <= PW'(MAX_LEN)) && (position >= PW'(prefix_length));

  always_comb begin
    if (match_total == 8'd0) begin
      stat_now = pmnc_pkg::STAT_NONE;
    end else if (match_total == 8'd1) begin
      stat_now = pmnc_pkg::STAT_ONE;
    end else begin
      stat_now = pmnc_pkg::STAT_MANY;
    end
  end

  // Input item latch and prefix read at the current position.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q  <= operation;
      ch_q  <= char_value;
      eos_q <= end_of_string;
      if (position < PW'(MAX_LEN)) begin
        pref_rd <= prefix_mem[position[AW-1:0]];
      end
    end
  end

  // Prefix memory write.
  always_ff @(posedge clk) begin
    if (do_prefix && (prefix_length < LW'(MAX_LEN))) begin
      prefix_mem[prefix_length[AW-1:0]] <= ch_q;
    end
  end

  // Address double buffer: write at the position, read for the
  // next-character lookup or for the report run.
  always_ff @(posedge clk) begin
    if (do_addr && (position < PW'(MAX_LEN))) begin
      buf_mem[back][position[AW-1:0]] <= ch_q;
    end
    if (cmd.end_rd && (prefix_length < LW'(MAX_LEN))) begin
      buf_rd <= buf_mem[back][prefix_length[AW-1:0]];
    end else if (cmd.rep_rd && (rep_k != '0)) begin
      buf_rd <= buf_mem[found_select][k_minus[AW-1:0]];
    end
  end

  // Match state; a clear item returns it to the reset values.
  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      prefix_length   <= '0;
      prefix_too_long <= 1'b0;
      found_select    <= 1'b0;
      found_length    <= '0;
      position        <= '0;
      still_matching  <= 1'b1;
      match_total     <= '0;
      for (int i = 0; i < pmnc_pkg::SET_WORDS; i++) begin
        enable_set[i] <= '0;
      end
    end else begin
      if (do_prefix) begin
        if (prefix_length < LW'(MAX_LEN)) begin
          prefix_length <= prefix_length + LW'(1);
        end else begin
          prefix_too_long <= 1'b1;
        end
      end
      if (do_addr) begin
        if ((position < PW'(prefix_length)) && (pref_rd != ch_q)) begin
          still_matching <= 1'b0;
        end
        if (position <= PW'(MAX_LEN)) begin
          position <= position + PW'(1);
        end
      end
      // Address completion: count, mark the following byte, swap buffers.
      if (cmd.end_do) begin
        if (is_match) begin
          if (match_total != pmnc_pkg::COUNT_MAX) begin
            match_total <= match_total + 8'd1;
          end
          if (position > PW'(prefix_length)) begin
            enable_set[buf_rd[7:6]][buf_rd[5:0]] <= 1'b1;
          end
          found_select <= back;
          found_length <= position[LW-1:0];
        end
        position       <= '0;
        still_matching <= 1'b1;
      end
    end
  end

  // Report run bookkeeping.
  always_ff @(posedge clk) begin
    if (rep_start) begin
      rep_status <= stat_now;
      rep_k      <= '0;
      if (stat_now == pmnc_pkg::STAT_ONE) begin
        rep_n <= KW'(1) + KW'(found_length);
      end else if (stat_now == pmnc_pkg::STAT_MANY) begin
        rep_n <= KW'(1) + KW'(pmnc_pkg::SET_WORDS);
      end else begin
        rep_n <= KW'(1);
      end
    end else if (cmd.rep_load) begin
      rep_k <= rep_k + KW'(1);
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.rep_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.rep_load) begin
      status      <= rep_status;
      match_count <= match_total;
      last        <= (rep_k + KW'(1) == rep_n);
      if (rep_k == '0) begin
        kind       <= pmnc_pkg::KIND_STATUS;
        out_char   <= 8'd0;
        set_word   <= 64'd0;
        word_index <= 2'd0;
      end else if (rep_status == pmnc_pkg::STAT_ONE) begin
        kind       <= pmnc_pkg::KIND_CHAR;
        out_char   <= buf_rd;
        set_word   <= 64'd0;
        word_index <= 2'd0;
      end else begin
        kind       <= pmnc_pkg::KIND_WORD;
        out_char   <= 8'd0;
        set_word   <= enable_set[k_minus[1:0]];
        word_index <= k_minus[1:0];
      end
    end
  end

  assign stat.op       = op_q;
  assign stat.eos      = eos_q;
  assign stat.rep_last = (rep_k + KW'(1) == rep_n);
  assign stat.out_free = !res_valid || res_ready;

endmodule

// ===== rtl/prefix_match_next_char_set_core.sv =====
// Prefix match next-character set: one item at a time. A clear, a prefix
// byte or an address byte passes through the execute state before the next
// item can be taken; the final byte of an address also passes through the
// end-read and end states, since the completion step reads the address
// buffer memory at the prefix length through its registered port. A report
// passes through the execute state, then a read state and a load state per
// result (1 + found length, 1 + 4, or 1 results); the load state waits while
// the result sink holds ready low. The output register lets a new item be
// accepted while the final result still waits. The memories need no clearing
// pass; data read from an unwritten entry is never used.
module prefix_match_next_char_set_core #(
  parameter int MAX_LEN = 32
) (
  input logic      clk,
  input logic      rst,
  pmnc_in_if.sink  item,
  pmnc_out_if.source result
);

  pmnc_pkg::dp_cmd_t    cmd;
  pmnc_pkg::dp_status_t stat;

  // Controller.
  pmnc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath.
  pmnc_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .operation     (item.operation),
    .char_value    (item.char_value),
    .end_of_string (item.end_of_string),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .kind          (result.kind),
    .status        (result.status),
    .match_count   (result.match_count),
    .out_char      (result.out_char),
    .set_word      (result.set_word),
    .word_index    (result.word_index),
    .last          (result.last)
  );

endmodule

// ===== rtl/pmnc_checker.sv =====
// Port-level assertions for the prefix match next-character set block,
// with the bind that attaches them to the top level's result channel.
// Depends on pmnc_pkg.
module pmnc_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  kind,
  input logic [1:0]  status,
  input logic [7:0]  out_char,
  input logic [63:0] set_word,
  input logic [1:0]  word_index,
  input logic        last
);

  // A result that is not taken stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result transfer dropped before it was taken");

  // A status item carries no byte and no set word.
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == pmnc_pkg::KIND_STATUS |->
      out_char == 8'd0 && set_word == 64'd0 && word_index == 2'd0)
    else $error("status item carries payload");

  // With no match the run is the status item alone.
  a_none_alone: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == pmnc_pkg::STAT_NONE |->
      last && kind == pmnc_pkg::KIND_STATUS)
    else $error("not-found report is longer than one item");

  // Address bytes belong to a single match, set words to several.
  a_kind_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind != pmnc_pkg::KIND_STATUS |->
      (kind == pmnc_pkg::KIND_CHAR && status == pmnc_pkg::STAT_ONE) ||
      (kind == pmnc_pkg::KIND_WORD && status == pmnc_pkg::STAT_MANY))
    else $error("result kind does not fit the report status");

endmodule

bind prefix_match_next_char_set_core pmnc_checker u_pmnc_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .kind       (result.kind),
  .status     (result.status),
  .out_char   (result.out_char),
  .set_word   (result.set_word),
  .word_index (result.word_index),
  .last       (result.last)
);

// ===== tb/prefix_match_next_char_set_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for prefix_match_next_char_set_core.
// Uses pmnc_pkg, pmnc_in_if and pmnc_out_if; drives clear, prefix, address and
// report transfers and checks every result transfer against a cycle-free predictor.
module prefix_match_next_char_set_core_test;

  localparam int MAX_LEN      = 32;
  localparam int RANDOM_ITEMS = 430;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_ITEMS   = 60;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic       eos;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [7:0]  match_count;
    logic [7:0]  out_char;
    logic [63:0] set_word;
    logic [1:0]  word_index;
    logic        last;
  } report_beat_t;

  logic clk;
  logic rst;

  pmnc_in_if  in_bus ();
  pmnc_out_if out_bus ();

  prefix_match_next_char_set_core #(
    .MAX_LEN(MAX_LEN)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .item  (in_bus),
    .result(out_bus)
  );

  // Stimulus and expectation stores.
  in_item_t     pending_items [$];
  report_beat_t expected_beats [$];
  logic [7:0]   stim_prefix [$];
  int           total_items;
  int           items_in;
  int           errors;

  // Predicted block state.
  logic [7:0]  pfx [MAX_LEN];
  int          pfx_len;
  logic        pfx_over;
  logic [7:0]  addr_buf [2][MAX_LEN];
  logic        found_sel;
  int          found_len;
  int          addr_pos;
  logic        addr_ok;
  logic [63:0] next_set [pmnc_pkg::SET_WORDS];
  logic [7:0]  hits;

  // Handshake pacing.
  int       gap_left;
  int       stall_left;
  int       hold_left;
  logic     hold_done;
  bit       send_quiet;
  bit       recv_quiet;
  in_item_t head;
  wire      calm    = items_in >= total_items - CALM_ITEMS;
  wire      holding = hold_left != 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Return the predicted state to its reset values.
  function automatic void clear_model();
    pfx_len   = 0;
    pfx_over  = 1'b0;
    found_sel = 1'b0;
    found_len = 0;
    addr_pos  = 0;
    addr_ok   = 1'b1;
    hits      = 8'd0;
    for (int w = 0; w < pmnc_pkg::SET_WORDS; w++) next_set[w] = '0;
  endfunction

  // Apply one accepted item to the predicted state and queue any results it causes.
  function automatic void update_match_state(logic [1:0] op, logic [7:0] ch, logic eos);
    logic         back;
    logic [7:0]   c;
    logic [1:0]   stat;
    int           n;
    report_beat_t beat;
    back = ~found_sel;
    case (op)
      pmnc_pkg::OP_CLEAR: begin
        clear_model();
      end
      pmnc_pkg::OP_PREFIX: begin
        if (ch != 8'd0) begin
          if (pfx_len < MAX_LEN) begin
            pfx[pfx_len] = ch;
            pfx_len++;
          end else begin
            pfx_over = 1'b1;
          end
        end
      end
      pmnc_pkg::OP_ADDR: begin
        if (ch != 8'd0) begin
          if (addr_pos < pfx_len && pfx[addr_pos] != ch) addr_ok = 1'b0;
          if (addr_pos < MAX_LEN) addr_buf[back][addr_pos] = ch;
          if (addr_pos <= MAX_LEN) addr_pos++;
        end
        // A completed address that matches is counted and becomes the found one.
        if (eos) begin
          if (addr_ok && !pfx_over && addr_pos <= MAX_LEN && addr_pos >= pfx_len) begin
            if (hits != pmnc_pkg::COUNT_MAX) hits++;
            if (addr_pos > pfx_len) begin
              c = addr_buf[back][pfx_len];
              next_set[c[7:6]][c[5:0]] = 1'b1;
            end
            found_sel = back;
            found_len = addr_pos;
          end
          addr_pos = 0;
          addr_ok  = 1'b1;
        end
      end
      default: begin
        // A report: the status item, then the found bytes or the set words.
        stat = (hits == 8'd0) ? pmnc_pkg::STAT_NONE :
               ((hits == 8'd1) ? pmnc_pkg::STAT_ONE : pmnc_pkg::STAT_MANY);
        n = 1;
        if (stat == pmnc_pkg::STAT_ONE) n += found_len;
        else if (stat == pmnc_pkg::STAT_MANY) n += pmnc_pkg::SET_WORDS;
        for (int k = 0; k < n; k++) begin
          beat             = '0;
          beat.kind        = pmnc_pkg::KIND_STATUS;
          beat.status      = stat;
          beat.match_count = hits;
          beat.last        = (k == n - 1);
          if (k > 0 && stat == pmnc_pkg::STAT_ONE) begin
            beat.kind     = pmnc_pkg::KIND_CHAR;
            beat.out_char = addr_buf[found_sel][k - 1];
          end else if (k > 0) begin
            beat.kind       = pmnc_pkg::KIND_WORD;
            beat.set_word   = next_set[(k - 1) % pmnc_pkg::SET_WORDS];
            beat.word_index = 2'((k - 1) % pmnc_pkg::SET_WORDS);
          end
          expected_beats.push_back(beat);
        end
      end
    endcase
  endfunction

  function automatic void queue_item(logic [1:0] op, logic [7:0] ch, logic eos);
    in_item_t it;
    it.op  = op;
    it.ch  = ch;
    it.eos = eos;
    pending_items.push_back(it);
  endfunction

  // Nonzero byte, often from a narrow range so that addresses share next bytes.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(8'h61, 8'h64));
  endfunction

  function automatic void add_prefix_byte(logic [7:0] b);
    queue_item(pmnc_pkg::OP_PREFIX, b, 1'($urandom_range(0, 1)));
    if (b != 8'd0 && stim_prefix.size() < MAX_LEN) stim_prefix.push_back(b);
  endfunction

  // An address that mostly starts with the current prefix, then tail_len bytes.
  function automatic void queue_address(int tail_len);
    int         total;
    logic [7:0] b;
    logic       eos_on_last;
    total       = stim_prefix.size() + tail_len;
    eos_on_last = $urandom_range(0, 3) != 0;
    for (int i = 0; i < total; i++) begin
      b = (i < stim_prefix.size()) ? stim_prefix[i] : pick_byte();
      if ($urandom_range(0, 15) == 0) b = pick_byte();
      if ($urandom_range(0, 19) == 0) queue_item(pmnc_pkg::OP_ADDR, 8'h00, 1'b0);
      queue_item(pmnc_pkg::OP_ADDR, b, eos_on_last && (i == total - 1));
    end
    if (!eos_on_last || total == 0) queue_item(pmnc_pkg::OP_ADDR, 8'h00, 1'b1);
  endfunction

  // Field comparison of one result against its expectation.
  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function automatic void check_beat(report_beat_t want);
    check_field("kind", want.kind, out_bus.kind);
    check_field("status", want.status, out_bus.status);
    check_field("match_count", want.match_count, out_bus.match_count);
    check_field("out_char", want.out_char, out_bus.out_char);
    check_field("set_word", want.set_word, out_bus.set_word);
    check_field("word_index", want.word_index, out_bus.word_index);
    check_field("last", want.last, out_bus.last);
  endfunction

  // Driver: presents queued items, with random gaps between transfers.
  always @(posedge clk) begin
    if (rst) begin
      in_bus.valid         <= 1'b0;
      in_bus.operation     <= pmnc_pkg::OP_CLEAR;
      in_bus.char_value    <= 8'd0;
      in_bus.end_of_string <= 1'b0;
      gap_left = 0;
    end else begin
      if ($urandom_range(0, 63) == 0) send_quiet = !send_quiet;
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          head = pending_items.pop_front();
          in_bus.valid         <= 1'b1;
          in_bus.operation     <= head.op;
          in_bus.char_value    <= head.ch;
          in_bus.end_of_string <= head.eos;
          if (!calm && !send_quiet && !holding && $urandom_range(0, 5) == 0)
            gap_left = $urandom_range(1, 16);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off so the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_bus.ready <= 1'b0;
      hold_left     <= 0;
      stall_left    <= 0;
      hold_done     <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) recv_quiet = !recv_quiet;
      if (!hold_done && items_in >= HOLD_AT) begin
        hold_done     <= 1'b1;
        hold_left     <= HOLD_CYCLES;
        out_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        out_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        out_bus.ready <= 1'b0;
      end else if (!calm && !recv_quiet && $urandom_range(0, 7) == 0) begin
        stall_left    <= $urandom_range(0, 15);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Monitor: checks each result transfer, then predicts from each input transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual kind %0d status %0d",
                   $time, out_bus.kind, out_bus.status);
        end else begin
          check_beat(expected_beats.pop_front());
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        update_match_state(in_bus.operation, in_bus.char_value, in_bus.end_of_string);
        items_in <= items_in + 1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int sel;
    int want;
    int goal;
    rst = 1'b1;
    clear_model();

    // Directed: report from reset, an empty address, extreme bytes, a report
    // inside an address, ignored zero bytes and a prefix grown after addresses.
    queue_item(pmnc_pkg::OP_REPORT, 8'h00, 1'b0);
    queue_item(pmnc_pkg::OP_ADDR, 8'h00, 1'b1);
    queue_item(pmnc_pkg::OP_REPORT, 8'hFF, 1'b1);
    queue_item(pmnc_pkg::OP_ADDR, 8'hFF, 1'b0);
    queue_item(pmnc_pkg::OP_ADDR, 8'h01, 1'b1);
    queue_item(pmnc_pkg::OP_REPORT, 8'h00, 1'b0);
    queue_item(pmnc_pkg::OP_CLEAR, 8'hAA, 1'b1);
    queue_item(pmnc_pkg::OP_PREFIX, 8'h00, 1'b0);
    queue_item(pmnc_pkg::OP_PREFIX, 8'h01, 1'b0);
    queue_item(pmnc_pkg::OP_PREFIX, 8'h80, 1'b1);
    queue_item(pmnc_pkg::OP_ADDR, 8'h01, 1'b0);
    queue_item(pmnc_pkg::OP_ADDR, 8'h80, 1'b0);
    queue_item(pmnc_pkg::OP_ADDR, 8'h00, 1'b1);
    queue_item(pmnc_pkg::OP_ADDR, 8'h01, 1'b0);
    queue_item(pmnc_pkg::OP_REPORT, 8'h55, 1'b0);
    queue_item(pmnc_pkg::OP_ADDR, 8'h81, 1'b1);
    queue_item(pmnc_pkg::OP_PREFIX, 8'h02, 1'b0);
    queue_item(pmnc_pkg::OP_ADDR, 8'h01, 1'b0);
    queue_item(pmnc_pkg::OP_ADDR, 8'h80, 1'b0);
    queue_item(pmnc_pkg::OP_ADDR, 8'h02, 1'b0);
    queue_item(pmnc_pkg::OP_ADDR, 8'h00, 1'b0);
    queue_item(pmnc_pkg::OP_ADDR, 8'h3F, 1'b1);
    queue_item(pmnc_pkg::OP_REPORT, 8'h00, 1'b0);
    queue_item(pmnc_pkg::OP_CLEAR, 8'h00, 1'b0);

    // Random: mostly well-formed addresses against a tracked prefix, with
    // reports, clears, prefix growth, overlong strings and noise mixed in.
    goal = pending_items.size() + RANDOM_ITEMS;
    while (pending_items.size() < goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        queue_item(pmnc_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
        stim_prefix.delete();
      end else if (sel < 15) begin
        repeat ($urandom_range(1, 3))
          add_prefix_byte(($urandom_range(0, 9) == 0) ? 8'h00 : pick_byte());
      end else if (sel < 17) begin
        repeat (MAX_LEN + 2) add_prefix_byte(pick_byte());
      end else if (sel < 30) begin
        queue_item(pmnc_pkg::OP_REPORT, 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
      end else if (sel < 34) begin
        if ($urandom_range(0, 1) == 0) begin
          queue_item(pmnc_pkg::OP_CLEAR, 8'h00, 1'b0);
          stim_prefix.delete();
        end
        want = MAX_LEN - 1 + $urandom_range(0, 3) - stim_prefix.size();
        queue_address((want < 0) ? 0 : want);
        queue_item(pmnc_pkg::OP_REPORT, 8'h00, 1'b0);
      end else if (sel < 39) begin
        queue_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
      end else begin
        queue_address($urandom_range(0, 4));
      end
    end
    total_items = pending_items.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (!(items_in == total_items && expected_beats.size() == 0)) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("** prefix_match_next_char_set_core: PASSED **");
    end else begin
      $display("** prefix_match_next_char_set_core: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10000000;
    $display("** prefix_match_next_char_set_core: FAILED **");
    $finish;
  end

endmodule
